>>> design/tbn_pkg.sv
`timescale 1ns / 1ps

package tbn_pkg;

  // Field and datapath widths
  localparam int IN_W          = 32;
  localparam int DIFF_W        = IN_W + 1;
  localparam int PROD_W        = 2 * DIFF_W;
  localparam int ACC_W         = PROD_W + 1;
  localparam int R_W           = 30;
  localparam int OUT_FRAC_BITS = 14;
  localparam int QW            = OUT_FRAC_BITS + 2;
  localparam int NUM_W         = R_W + OUT_FRAC_BITS + 1;
  localparam int FIELD_W       = 16;
  localparam int UNIT_W        = 64;
  localparam int ROOT_W        = 32;
  localparam int ROOT_STEPS    = 32;

  // Stream widths
  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 96;

  // Corner codes
  localparam logic [1:0] CORNER_A = 2'd0;
  localparam logic [1:0] CORNER_B = 2'd1;
  localparam logic [1:0] CORNER_C = 2'd2;

  // Command to the root / divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } sd_cmd_t;

  // Status from the root / divide unit
  typedef struct packed {
    logic busy;
    logic done;
  } sd_stat_t;

endpackage

>>> design/tbn_sqdiv.sv
`timescale 1ns / 1ps

// Iterative square root (two bits a step) and restoring divide (one bit a step)
// sharing one compare and subtract.
module tbn_sqdiv (
  input  logic                         clk,
  input  logic                         rst,
  input  tbn_pkg::sd_cmd_t             cmd,
  input  logic [tbn_pkg::UNIT_W-1:0]   opa,
  input  logic [tbn_pkg::ROOT_W-1:0]   opb,
  output tbn_pkg::sd_stat_t            stat,
  output logic [tbn_pkg::ROOT_W-1:0]   result
);
  import tbn_pkg::*;

  logic [UNIT_W-1:0] acc;
  logic [UNIT_W-1:0] rr;
  logic [UNIT_W-1:0] bitm;
  logic [4:0]        cnt;
  logic              busy;
  logic              done;
  logic              is_div;
  logic [UNIT_W-1:0] trial;
  logic              take;

  // Shared compare operand
  assign trial = is_div ? bitm : (rr + bitm);
  assign take  = (acc >= trial);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: load on start, one step per busy cycle
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      is_div <= cmd.is_div;
      acc    <= opa;
      rr     <= '0;
      if (cmd.is_div) begin
        bitm <= UNIT_W'(opb) << (QW - 1);
        cnt  <= 5'(QW - 1);
      end else begin
        bitm <= UNIT_W'(1) << (UNIT_W - 2);
        cnt  <= 5'(ROOT_STEPS - 1);
      end
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (take) begin
        acc <= acc - trial;
      end
      if (is_div) begin
        rr   <= {rr[UNIT_W-2:0], take};
        bitm <= bitm >> 1;
      end else begin
        rr   <= take ? ((rr >> 1) + bitm) : (rr >> 1);
        bitm <= bitm >> 2;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = rr[ROOT_W-1:0];

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    !(cmd.start && busy)) else $error("unit restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without work");
  a_root_bit: assert property (@(posedge clk) disable iff (rst)
    (busy && !is_div) |-> $onehot0(bitm)) else $error("root bit not one-hot");

endmodule

>>> design/triangle_tangent_binormal.sv
`timescale 1ns / 1ps
// Corners 0 and 1 are stored on acceptance and code 3 is ignored; the block stays ready.
// Corner 2 runs 14 products on the shared 33x33 multiplier (multiply state, then accumulate
// state), then per vector a leading-bit shift, three squares, a 32-step square root and
// three 16-step divides; a degenerate triangle goes from the products straight to output.
// One triangle at a time; a finished result waits in the output register.
// Reset (rst, synchronous) clears the stored corners to zero and empties the output.

module triangle_tangent_binormal (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // corner[1:0], pos_x, pos_y, pos_z, tex_u, tex_v (32 each), zero fill
  input  logic [tbn_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // tangent_x, tangent_y, tangent_z, binormal_x, binormal_y, binormal_z (16 each)
  output logic [tbn_pkg::OUT_DATA_W-1:0]   m_tdata,
  // degenerate
  output logic [0:0]                       m_tuser
);
  import tbn_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_MUL       = 13'b0000000000010,
    S_ACC       = 13'b0000000000100,
    S_LOAD      = 13'b0000000001000,
    S_SHIFT     = 13'b0000000010000,
    S_SQ_MUL    = 13'b0000000100000,
    S_SQ_ACC    = 13'b0000001000000,
    S_ROOT_GO   = 13'b0000010000000,
    S_ROOT_WAIT = 13'b0000100000000,
    S_DIV_GO    = 13'b0001000000000,
    S_DIV_WAIT  = 13'b0010000000000,
    S_OUT       = 13'b0100000000000,
    S_SPARE     = 13'b1000000000000
  } state_t;

  state_t state;

  // Input fields
  logic [1:0]      in_corner;
  logic [IN_W-1:0] in_pos [3];
  logic [IN_W-1:0] in_u;
  logic [IN_W-1:0] in_v;

  assign in_corner = s_tdata[1:0];
  assign in_pos[0] = s_tdata[33:2];
  assign in_pos[1] = s_tdata[65:34];
  assign in_pos[2] = s_tdata[97:66];
  assign in_u      = s_tdata[129:98];
  assign in_v      = s_tdata[161:130];

  // Stored corners
  logic [IN_W-1:0] pos0 [3];
  logic [IN_W-1:0] pos1 [3];
  logic [IN_W-1:0] u0, v0, u1, v1;

  // Differences
  logic signed [DIFF_W-1:0] dp1 [3];
  logic signed [DIFF_W-1:0] dp2 [3];
  logic signed [DIFF_W-1:0] du1, dv1, du2, dv2;

  // Products
  logic signed [DIFF_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  res [7];
  logic [3:0]               step;
  logic [2:0]               pidx;
  logic [1:0]               axis;

  // Normalization
  logic              vsel;
  logic [ACC_W-1:0]  mag [3];
  logic [2:0]        sgn;
  logic [ACC_W-1:0]  mag_or;
  logic [1:0]        ridx;
  logic [2:0]        oidx;
  logic [R_W-1:0]    r_cur;
  logic [UNIT_W-1:0] ssum;
  logic [ROOT_W-1:0] nroot;
  logic [FIELD_W-1:0] vec_out [6];
  logic               deg;
  logic               dneg;
  logic               flip;
  logic               vec_zero;
  logic [FIELD_W-1:0] qf;
  logic [FIELD_W-1:0] code;

  // Root / divide unit
  sd_cmd_t           sd_cmd;
  sd_stat_t          sd_stat;
  logic [UNIT_W-1:0] sd_opa;
  logic [ROOT_W-1:0] sd_res;

  logic in_fire;
  logic out_free;

  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign pidx  = step[3:1];
  assign axis  = (pidx >= 3'd4) ? 2'(pidx - 3'd4) : 2'(pidx - 3'd1);
  assign dneg  = res[0][ACC_W-1];
  assign flip  = vsel ? dneg : !dneg;
  assign mag_or = mag[0] | mag[1] | mag[2];
  assign r_cur = mag[ridx][ACC_W-1 -: R_W];
  assign oidx  = (vsel ? 3'd3 : 3'd0) + 3'(ridx);
  assign vec_zero = vsel ? (res[4] == '0 && res[5] == '0 && res[6] == '0)
                         : (res[1] == '0 && res[2] == '0 && res[3] == '0);

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_SQ_MUL) begin
      mul_a = $signed(DIFF_W'(r_cur));
      mul_b = $signed(DIFF_W'(r_cur));
    end else begin
      case (pidx) inside
        3'd0: begin
          mul_a = step[0] ? dv1 : du1;
          mul_b = step[0] ? du2 : dv2;
        end
        [3'd1:3'd3]: begin
          mul_a = step[0] ? dp1[axis] : dv1;
          mul_b = step[0] ? dv2 : dp2[axis];
        end
        default: begin
          mul_a = step[0] ? du1 : dp1[axis];
          mul_b = step[0] ? dp2[axis] : du2;
        end
      endcase
    end
  end

  // Divider command and operand
  always_comb begin
    sd_cmd.start  = (state == S_ROOT_GO) || (state == S_DIV_GO);
    sd_cmd.is_div = (state == S_DIV_GO);
    if (state == S_DIV_GO) begin
      sd_opa = UNIT_W'({r_cur, {OUT_FRAC_BITS{1'b0}}} + NUM_W'(nroot >> 1));
    end else begin
      sd_opa = ssum;
    end
  end

  tbn_sqdiv u_sqdiv (
    .clk    (clk),
    .rst    (rst),
    .cmd    (sd_cmd),
    .opa    (sd_opa),
    .opb    (nroot),
    .stat   (sd_stat),
    .result (sd_res)
  );

  // Signed output code from the quotient
  assign qf   = FIELD_W'(sd_res[QW-1:0]);
  assign code = sgn[ridx] ? (~qf + FIELD_W'(1)) : qf;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire && in_corner == CORNER_C) begin
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_ACC;
        S_ACC: state <= (step == 4'd13) ? S_LOAD : S_MUL;
        S_LOAD: begin
          if (res[0] == '0) begin
            state <= S_OUT;
          end else if (vec_zero) begin
            state <= vsel ? S_OUT : S_LOAD;
          end else begin
            state <= S_SHIFT;
          end
        end
        S_SHIFT: state <= mag_or[ACC_W-1] ? S_SQ_MUL : S_SHIFT;
        S_SQ_MUL: state <= S_SQ_ACC;
        S_SQ_ACC: state <= (ridx == 2'd2) ? S_ROOT_GO : S_SQ_MUL;
        S_ROOT_GO: state <= S_ROOT_WAIT;
        S_ROOT_WAIT: state <= sd_stat.done ? S_DIV_GO : S_ROOT_WAIT;
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (sd_stat.done) begin
            if (ridx != 2'd2) begin
              state <= S_DIV_GO;
            end else begin
              state <= vsel ? S_OUT : S_LOAD;
            end
          end
        end
        S_OUT: state <= out_free ? S_IDLE : S_OUT;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Store corners
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        pos0[i] <= '0;
        pos1[i] <= '0;
      end
      u0 <= '0;
      v0 <= '0;
      u1 <= '0;
      v1 <= '0;
    end else if (in_fire) begin
      if (in_corner == CORNER_A) begin
        for (int i = 0; i < 3; i++) pos0[i] <= in_pos[i];
        u0 <= in_u;
        v0 <= in_v;
      end else if (in_corner == CORNER_B) begin
        for (int i = 0; i < 3; i++) pos1[i] <= in_pos[i];
        u1 <= in_u;
        v1 <= in_v;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        step <= '0;
        vsel <= 1'b0;
        deg  <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          dp1[i] <= $signed({pos1[i][IN_W-1], pos1[i]}) - $signed({pos0[i][IN_W-1], pos0[i]});
          dp2[i] <= $signed({in_pos[i][IN_W-1], in_pos[i]})
                  - $signed({pos1[i][IN_W-1], pos1[i]});
        end
        du1 <= $signed({u1[IN_W-1], u1}) - $signed({u0[IN_W-1], u0});
        dv1 <= $signed({v1[IN_W-1], v1}) - $signed({v0[IN_W-1], v0});
        du2 <= $signed({in_u[IN_W-1], in_u}) - $signed({u1[IN_W-1], u1});
        dv2 <= $signed({in_v[IN_W-1], in_v}) - $signed({v1[IN_W-1], v1});
      end
      S_MUL, S_SQ_MUL: begin
        prod <= mul_a * mul_b;
      end
      S_ACC: begin
        if (!step[0]) begin
          acc <= ACC_W'(prod);
        end else begin
          res[pidx] <= acc - ACC_W'(prod);
        end
        step <= step + 4'd1;
      end
      S_LOAD: begin
        ridx <= '0;
        if (res[0] == '0) begin
          deg <= 1'b1;
          for (int i = 0; i < 6; i++) vec_out[i] <= '0;
        end else begin
          for (int i = 0; i < 3; i++) begin
            logic signed [ACC_W-1:0] x;
            x = vsel ? res[3'(4 + i)] : res[3'(1 + i)];
            mag[i] <= x[ACC_W-1] ? (~x + ACC_W'(1)) : x;
            sgn[i] <= x[ACC_W-1] ^ flip;
          end
          if (vec_zero) begin
            for (int i = 0; i < 3; i++) vec_out[3'(vsel ? 3 + i : i)] <= '0;
            vsel <= 1'b1;
          end
        end
      end
      S_SHIFT: begin
        // Bring the largest magnitude up to the top bit
        if (!mag_or[ACC_W-1]) begin
          for (int i = 0; i < 3; i++) begin
            mag[i] <= (mag_or[ACC_W-1 -: 8] == '0) ? (mag[i] << 8) : (mag[i] << 1);
          end
        end
      end
      S_SQ_ACC: begin
        ssum <= ((ridx == 2'd0) ? '0 : ssum) + UNIT_W'(unsigned'(prod));
        ridx <= (ridx == 2'd2) ? 2'd0 : ridx + 2'd1;
      end
      S_ROOT_WAIT: begin
        if (sd_stat.done) begin
          nroot <= sd_res;
          ridx  <= '0;
        end
      end
      S_DIV_WAIT: begin
        if (sd_stat.done) begin
          vec_out[oidx] <= code;
          ridx <= ridx + 2'd1;
          if (ridx == 2'd2) begin
            vsel <= 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_tdata    <= {vec_out[5], vec_out[4], vec_out[3], vec_out[2], vec_out[1], vec_out[0]};
      m_tuser[0] <= deg;
    end
  end

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0)) else $error("degenerate result not zero");
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[15:0]) >= -16'sd16384 && $signed(m_tdata[15:0]) <= 16'sd16384))
    else $error("tangent x out of range");
  a_scaled: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQ_MUL) |-> mag_or[ACC_W-1]) else $error("magnitudes not scaled");
  a_root_to_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT_WAIT && sd_stat.done) |=> (state == S_DIV_GO))
    else $error("root result not followed by divide");

endmodule

>>> tb/sv/triangle_tangent_binormal_test.sv
`timescale 1ns / 1ps

module triangle_tangent_binormal_test;
  import tbn_pkg::*;

  localparam logic [1:0] CORNER_SKIP = 2'd3;
  localparam int IDLE_PCT = 26;
  localparam int HOLD_CYCLES = 800;
  localparam int DRAIN_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 6000;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [15:0] tangent [3];
    logic [15:0] binormal [3];
    logic        degenerate;
  } frame_t;

  // Expected tangent frames per triangle, predicted from accepted vertices
  class frame_scoreboard;
    logic [31:0] corner_pos [6];
    logic [31:0] corner_tex [4];
    frame_t      frames_q [$];
    int          errors;

    function new();
      foreach (corner_pos[i]) corner_pos[i] = '0;
      foreach (corner_tex[i]) corner_tex[i] = '0;
      errors = 0;
    endfunction

    function wide_t sx(logic [31:0] w);
      return {{96{w[31]}}, w};
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] s);
      logic [63:0] root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (s >= root + bitv) begin
          s = s - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    // Scale to a 30-bit leading magnitude, then divide by the rounded-down root
    function void unit_vec(wide_t v [3], bit flip, output logic [15:0] code [3]);
      wide_t       mag [3];
      bit          neg [3];
      logic [63:0] r [3];
      logic [63:0] sum, n, q;
      int          len;
      len = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        neg[i] = v[i][127];
        mag[i] = neg[i] ? -v[i] : v[i];
        for (int b = 127; b >= 0; b--)
          if (mag[i][b]) begin
            if (b + 1 > len) len = b + 1;
            break;
          end
      end
      if (len == 0) begin
        foreach (code[i]) code[i] = '0;
        return;
      end
      for (int i = 0; i < 3; i++) begin
        if (len > 30) r[i] = 64'(mag[i] >> (len - 30));
        else r[i] = 64'(mag[i] << (30 - len));
        sum = sum + r[i] * r[i];
      end
      n = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
        q = ((r[i] << OUT_FRAC_BITS) + (n >> 1)) / n;
        code[i] = (neg[i] != flip) ? 16'(-q) : 16'(q);
      end
    endfunction

    function void note_vertex(logic [IN_DATA_W-1:0] d);
      logic [1:0]  corner;
      logic [31:0] pos [3];
      logic [31:0] tu, tv;
      wide_t       dp1 [3], dp2 [3], yv [3], zv [3];
      wide_t       du1, dv1, du2, dv2, det;
      frame_t      f;
      corner = d[1:0];
      for (int i = 0; i < 3; i++) pos[i] = d[2 + 32*i +: 32];
      tu = d[98 +: 32];
      tv = d[130 +: 32];
      if (corner == CORNER_A || corner == CORNER_B) begin
        for (int i = 0; i < 3; i++) corner_pos[corner*3 + i] = pos[i];
        corner_tex[corner*2] = tu;
        corner_tex[corner*2 + 1] = tv;
        return;
      end
      if (corner != CORNER_C) return;
      for (int i = 0; i < 3; i++) begin
        dp1[i] = sx(corner_pos[3 + i]) - sx(corner_pos[i]);
        dp2[i] = sx(pos[i]) - sx(corner_pos[3 + i]);
      end
      du1 = sx(corner_tex[2]) - sx(corner_tex[0]);
      dv1 = sx(corner_tex[3]) - sx(corner_tex[1]);
      du2 = sx(tu) - sx(corner_tex[2]);
      dv2 = sx(tv) - sx(corner_tex[3]);
      det = du1 * dv2 - dv1 * du2;
      f.degenerate = (det == 0);
      if (det == 0) begin
        foreach (f.tangent[i]) f.tangent[i] = '0;
        foreach (f.binormal[i]) f.binormal[i] = '0;
      end else begin
        for (int i = 0; i < 3; i++) begin
          yv[i] = dv1 * dp2[i] - dp1[i] * dv2;
          zv[i] = dp1[i] * du2 - du1 * dp2[i];
        end
        unit_vec(yv, !det[127], f.tangent);
        unit_vec(zv, det[127], f.binormal);
      end
      frames_q.push_back(f);
    endfunction

    function void check_frame(logic [OUT_DATA_W-1:0] d, logic deg);
      frame_t f;
      string  axis [3] = '{"x", "y", "z"};
      if (frames_q.size() == 0) begin
        $error("unexpected frame: tdata=%h degenerate=%0d", d, deg);
        errors++;
        return;
      end
      f = frames_q.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (d[16*i +: 16] !== f.tangent[i]) begin
          $error("tangent_%s: expected %h, got %h", axis[i], f.tangent[i], d[16*i +: 16]);
          errors++;
        end
        if (d[48 + 16*i +: 16] !== f.binormal[i]) begin
          $error("binormal_%s: expected %h, got %h", axis[i], f.binormal[i],
                 d[48 + 16*i +: 16]);
          errors++;
        end
      end
      if (deg !== f.degenerate) begin
        $error("degenerate: expected %0d, got %0d", f.degenerate, deg);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0]            m_tuser;

  frame_scoreboard sb;
  bit              steady;
  bit              hold_go;
  bit              hold_taken;
  int              hold_left;
  int              quiet_cycles;

  triangle_tangent_binormal u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Record each input and output transaction
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_vertex(s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_frame(m_tdata, m_tuser[0]);
  end

  // Receiver: random back-pressure, one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_vertex(logic [1:0] corner, logic [31:0] px, logic [31:0] py,
                             logic [31:0] pz, logic [31:0] tu, logic [31:0] tv);
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, tv, tu, pz, py, px, corner};
    do @(posedge clk); while (!s_tready);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_coord();
    logic [31:0] pick [5] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff};
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 20000)) - 10000) << $urandom_range(0, 16);
      2: return pick[$urandom_range(4)];
      default: return 32'($signed($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  // Three corners with random content; sometimes a collapsed UV edge
  task automatic send_triangle();
    logic [31:0] u1, v1;
    u1 = rand_coord();
    v1 = rand_coord();
    send_vertex(CORNER_A, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                rand_coord());
    send_vertex(CORNER_B, rand_coord(), rand_coord(), rand_coord(), u1, v1);
    if ($urandom_range(7) == 0)
      send_vertex(CORNER_C, rand_coord(), rand_coord(), rand_coord(), u1, v1);
    else
      send_vertex(CORNER_C, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord());
  endtask

  task automatic send_random(int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        send_vertex(2'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom,
                    $urandom);
        sent++;
      end else begin
        send_triangle();
        sent += 3;
      end
    end
  endtask

  // Stop offering, let the last transaction be recorded, then wait for every frame
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.frames_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    steady = 1'b0;
    hold_go = 1'b0;
    hold_taken = 1'b0;
    hold_left = 0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Corner 2 straight after reset sees zero corners: degenerate
    send_vertex(CORNER_C, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0001_0000,
                32'h0000_8000);
    // Skipped corner code leaves state alone
    send_vertex(CORNER_SKIP, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                32'hffff_ffff, 32'hffff_ffff);
    // Simple right triangle
    send_vertex(CORNER_A, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_vertex(CORNER_B, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
    send_vertex(CORNER_C, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0001_0000,
                32'h0001_0000);
    // Corner 2 again reuses the kept corners
    send_vertex(CORNER_C, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, 32'h8000_0000,
                32'h7fff_ffff);
    // Extremes of every coordinate
    send_vertex(CORNER_A, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                32'h8000_0000);
    send_vertex(CORNER_B, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                32'h7fff_ffff);
    send_vertex(CORNER_C, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h7fff_ffff);
    // Flat positions with a valid UV triangle: zero-length vectors
    send_vertex(CORNER_A, 32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 32'h0, 32'h0);
    send_vertex(CORNER_B, 32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 32'h0001_0000,
                32'h0);
    send_vertex(CORNER_C, 32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 32'h0,
                32'h0001_0000);
    // Collinear UVs: degenerate
    send_vertex(CORNER_C, 32'h0005_0000, 32'h0, 32'h0001_0000, 32'h0002_0000,
                32'h0);
    // Tiny differences, forcing a left shift
    send_vertex(CORNER_A, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0);
    send_vertex(CORNER_B, 32'h0, 32'h1, 32'h0, 32'h1, 32'h0);
    send_vertex(CORNER_C, 32'h0, 32'h0, 32'h1, 32'h1, 32'h1);

    send_random(300);

    // Sender pause: let every frame come out
    wait_drained();

    // Long receiver hold-off while the sender keeps offering
    hold_go = 1'b1;
    send_random(24);

    // Stretch without idling on either side
    steady = 1'b1;
    send_random(120);
    steady = 1'b0;

    send_random(240);
    s_tvalid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.frames_q.size() != 0) begin
      $error("%0d frames never arrived", sb.frames_q.size());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
